FILE: design/lfu_cache_policy_defines.svh
// assertion helpers used by the cache policy datapath
`ifndef LFU_CACHE_POLICY_DEFINES_SVH
`define LFU_CACHE_POLICY_DEFINES_SVH

// property that must hold at every clock edge out of reset
`define LCP_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// property whose consequent must hold in the cycle after the antecedent
`define LCP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: design/lcp_pkg.sv
package lcp_pkg;

  localparam int KEY_W = 32;
  localparam int VAL_W = 32;
  localparam int CAP_W = 5;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;
  localparam logic signed [VAL_W-1:0] VAL_NONE = -32'sd1;
  localparam logic signed [KEY_W-1:0] KEY_NONE = 32'sd0;

  typedef enum logic [0:0] {
    MODE_GET = 1'b0,
    MODE_PUT = 1'b1
  } mode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_UPDATE,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic update;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic scan_last;
    logic out_free;
  } sts_t;

endpackage

FILE: design/lcp_req_if.sv
interface lcp_req_if;
  import lcp_pkg::*;
  logic                    valid;
  logic                    ready;
  logic                    mode;
  logic signed [KEY_W-1:0] lookup_key;
  logic signed [VAL_W-1:0] store_value;

  modport source (output valid, mode, lookup_key, store_value, input ready);
  modport sink (input valid, mode, lookup_key, store_value, output ready);
endinterface

FILE: design/lcp_rsp_if.sv
interface lcp_rsp_if;
  import lcp_pkg::*;
  logic                    valid;
  logic                    ready;
  logic                    hit;
  logic signed [VAL_W-1:0] read_value;
  logic                    evicted;
  logic signed [KEY_W-1:0] evicted_key;

  modport source (output valid, hit, read_value, evicted, evicted_key, input ready);
  modport sink (input valid, hit, read_value, evicted, evicted_key, output ready);
endinterface

FILE: design/lcp_ctrl.sv
module lcp_ctrl
  import lcp_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (sts.scan_last) state_nxt = ST_DRAIN;
      end
      ST_DRAIN:  state_nxt = ST_UPDATE;
      ST_UPDATE: state_nxt = ST_DONE;
      ST_DONE: begin
        if (sts.out_free) state_nxt = ST_IDLE;
      end
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_SCAN:   cmd.scan = 1'b1;
      ST_DRAIN:  cmd = '0;
      ST_UPDATE: cmd.update = 1'b1;
      ST_DONE:   cmd.emit = sts.out_free;
      default:   cmd = '0;
    endcase
  end

endmodule

FILE: design/lcp_dp.sv
`include "lfu_cache_policy_defines.svh"

module lcp_dp
  import lcp_pkg::*;
#(
  parameter int ENTRIES    = 16,
  parameter int COUNT_BITS = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  cmd_t                    cmd,
  output sts_t                    sts,
  input  logic                    cfg_we,
  input  logic [CAP_W-1:0]        cfg_wdata,
  input  logic                    req_mode,
  input  logic signed [KEY_W-1:0] req_key,
  input  logic signed [VAL_W-1:0] req_value,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic                    out_hit,
  output logic signed [VAL_W-1:0] out_read_value,
  output logic                    out_evicted,
  output logic signed [KEY_W-1:0] out_evicted_key
);

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int OCC_W = $clog2(ENTRIES + 1);
  localparam int CMP_W = (OCC_W > CAP_W) ? OCC_W : CAP_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);
  localparam logic [OCC_W-1:0] OCC_FULL = OCC_W'(ENTRIES);
  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;
  localparam logic [COUNT_BITS-1:0] CNT_ONE = COUNT_BITS'(1);

  logic [CAP_W-1:0] cap_r;

  // request word
  logic                    mode_r;
  logic signed [KEY_W-1:0] key_r;
  logic signed [VAL_W-1:0] val_r;

  // entry storage
  logic [ENTRIES-1:0]      valid_r;
  logic [IDX_W-1:0]        rank_r [ENTRIES];
  logic [OCC_W-1:0]        occ_r;
  logic [KEY_W-1:0]        key_mem [ENTRIES];
  logic [VAL_W-1:0]        val_mem [ENTRIES];
  logic [COUNT_BITS-1:0]   cnt_mem [ENTRIES];
  logic [KEY_W-1:0]        key_q;
  logic [VAL_W-1:0]        val_q;
  logic [COUNT_BITS-1:0]   cnt_q;

  // scan pipeline
  logic [IDX_W-1:0]        ptr_r;
  logic                    ev_v_r;
  logic [IDX_W-1:0]        ev_idx_r;

  // scan trackers
  logic                    hit_r;
  logic [IDX_W-1:0]        found_r;
  logic [VAL_W-1:0]        found_val_r;
  logic [COUNT_BITS-1:0]   found_cnt_r;
  logic [IDX_W-1:0]        found_rank_r;
  logic                    vic_have_r;
  logic [IDX_W-1:0]        vic_r;
  logic [KEY_W-1:0]        vic_key_r;
  logic [COUNT_BITS-1:0]   vic_cnt_r;
  logic [IDX_W-1:0]        vic_rank_r;
  logic                    free_have_r;
  logic [IDX_W-1:0]        free_r;

  // pending result
  logic                    res_hit_r;
  logic signed [VAL_W-1:0] res_val_r;
  logic                    res_ev_r;
  logic signed [KEY_W-1:0] res_key_r;
  logic                    out_valid_r;

  logic                    e_valid;
  logic [IDX_W-1:0]        e_rank;
  logic                    e_match;
  logic                    e_better;

  logic                    cap_zero;
  logic                    full;
  logic                    do_touch;
  logic                    do_evict;
  logic                    do_ins;
  logic                    act;
  logic [IDX_W-1:0]        tgt;
  logic [IDX_W-1:0]        thr;
  logic [COUNT_BITS-1:0]   cnt_wr;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else if (cfg_we) begin
      cap_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r <= req_mode;
      key_r  <= req_key;
      val_r  <= req_value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r  <= '0;
      ev_v_r <= 1'b0;
    end else begin
      ev_v_r <= cmd.scan;
      if (cmd.load) begin
        ptr_r <= '0;
      end else if (cmd.scan) begin
        ptr_r <= ptr_r + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    ev_idx_r <= ptr_r;
  end

  assign sts.scan_last = (ptr_r == LAST_IDX);
  assign sts.out_free  = !out_valid_r || out_ready;

  // one entry evaluated per cycle, in the cycle after its read address
  assign e_valid  = ev_v_r && valid_r[ev_idx_r];
  assign e_rank   = rank_r[ev_idx_r];
  assign e_match  = e_valid && (key_q == key_r) && !hit_r;
  assign e_better = e_valid && (!vic_have_r || (cnt_q < vic_cnt_r) ||
                    ((cnt_q == vic_cnt_r) && (e_rank > vic_rank_r)));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r       <= 1'b0;
      vic_have_r  <= 1'b0;
      free_have_r <= 1'b0;
    end else if (cmd.load) begin
      hit_r       <= 1'b0;
      vic_have_r  <= 1'b0;
      free_have_r <= 1'b0;
    end else begin
      if (e_match) hit_r <= 1'b1;
      if (e_better) vic_have_r <= 1'b1;
      if (ev_v_r && !valid_r[ev_idx_r] && !free_have_r) free_have_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (e_match) begin
      found_r      <= ev_idx_r;
      found_val_r  <= val_q;
      found_cnt_r  <= cnt_q;
      found_rank_r <= e_rank;
    end
    if (e_better) begin
      vic_r      <= ev_idx_r;
      vic_key_r  <= key_q;
      vic_cnt_r  <= cnt_q;
      vic_rank_r <= e_rank;
    end
    if (ev_v_r && !valid_r[ev_idx_r] && !free_have_r) begin
      free_r <= ev_idx_r;
    end
  end

  // full when occupancy reaches the capacity, which saturates at the entry count
  assign cap_zero = (cap_r == '0);
  assign full     = (CMP_W'(occ_r) >= CMP_W'(cap_r)) || (occ_r == OCC_FULL);
  assign do_touch = cmd.update && hit_r && ((mode_r == MODE_GET) || !cap_zero);
  assign do_evict = cmd.update && (mode_r == MODE_PUT) && !cap_zero && !hit_r && full;
  assign do_ins   = cmd.update && (mode_r == MODE_PUT) && !cap_zero && !hit_r && !full;
  assign act      = do_touch || do_evict || do_ins;

  always_comb begin
    tgt = free_r;
    thr = '0;
    if (do_touch) begin
      tgt = found_r;
      thr = found_rank_r;
    end else if (do_evict) begin
      tgt = vic_r;
      thr = vic_rank_r;
    end
  end

  assign cnt_wr = do_touch ? ((found_cnt_r == CNT_MAX) ? found_cnt_r : found_cnt_r + CNT_ONE)
                           : CNT_ONE;

  always_ff @(posedge clk) begin
    if (do_evict || do_ins) key_mem[tgt] <= key_r;
    if (act && (mode_r == MODE_PUT)) val_mem[tgt] <= val_r;
    if (act) cnt_mem[tgt] <= cnt_wr;
    key_q <= key_mem[ptr_r];
    val_q <= val_mem[ptr_r];
    cnt_q <= cnt_mem[ptr_r];
  end

  // recency lanes: entries newer than the target age by one, all of them on a fresh insert
  for (genvar g = 0; g < ENTRIES; g++) begin : g_lane
    always_ff @(posedge clk) begin
      if (act) begin
        if (tgt == IDX_W'(g)) begin
          rank_r[g] <= '0;
        end else if (valid_r[g] && (do_ins || (rank_r[g] < thr))) begin
          rank_r[g] <= rank_r[g] + IDX_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      occ_r   <= '0;
    end else if (act) begin
      valid_r[tgt] <= 1'b1;
      if (do_ins) occ_r <= occ_r + OCC_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      res_hit_r <= hit_r;
      res_val_r <= ((mode_r == MODE_GET) && hit_r) ? found_val_r : VAL_NONE;
      res_ev_r  <= do_evict;
      res_key_r <= do_evict ? vic_key_r : KEY_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_hit         <= res_hit_r;
      out_read_value  <= res_val_r;
      out_evicted     <= res_ev_r;
      out_evicted_key <= res_key_r;
    end
  end

  assign out_valid = out_valid_r;

  `LCP_ASSERT_ALWAYS(a_occ_count, $countones(valid_r) == occ_r, "occupancy out of step")
  `LCP_ASSERT_ALWAYS(a_occ_max, occ_r <= OCC_FULL, "occupancy above entry count")
  `LCP_ASSERT_NEXT(a_emit, cmd.emit, out_valid_r, "result not presented")
  `LCP_ASSERT_ALWAYS(a_ev_hit, !out_valid_r || !(out_hit && out_evicted), "evict on a hit")

endmodule

FILE: design/lfu_cache_policy.sv
// lfu_cache_policy: fully associative key/value store, least frequently used
// replacement with least recently used tie-break.
// in_req carries one request word (mode get/put, lookup_key, store_value);
// out_rsp returns exactly one result word per request (hit, read_value,
// evicted, evicted_key). both use valid/ready, a word moves when both high.
// cfg_we/cfg_wdata write cache_capacity; write it only while idle.
// one request at a time, in the steps accept, scan of every entry (one entry
// per cycle through the key/value/count memory read port), drain, update,
// and loading of the output register; the next request is accepted only
// after the result is in the output register.
// the output register lets the next request enter while a result waits;
// if out_rsp stays stalled, the finished result after it is held back and
// no third request is accepted.
// reset (rst_n low, synchronous) empties the store and sets capacity to 16,
// with no clearing pass.
module lfu_cache_policy
  import lcp_pkg::*;
#(
  parameter int ENTRIES    = 16,
  parameter int COUNT_BITS = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  lcp_req_if.sink          in_req,
  lcp_rsp_if.source        out_rsp,
  input  logic             cfg_we,
  input  logic [CAP_W-1:0] cfg_wdata
);

  cmd_t cmd;
  sts_t sts;

  lcp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_req.valid),
    .in_ready (in_req.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  lcp_dp #(
    .ENTRIES    (ENTRIES),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .req_mode        (in_req.mode),
    .req_key         (in_req.lookup_key),
    .req_value       (in_req.store_value),
    .out_valid       (out_rsp.valid),
    .out_ready       (out_rsp.ready),
    .out_hit         (out_rsp.hit),
    .out_read_value  (out_rsp.read_value),
    .out_evicted     (out_rsp.evicted),
    .out_evicted_key (out_rsp.evicted_key)
  );

endmodule
